// ===== rtl/core/calendar_seconds_adder_assert.svh =====
// Assertion macros used by the calendar seconds adder RTL.
`ifndef CALENDAR_SECONDS_ADDER_ASSERT_SVH
`define CALENDAR_SECONDS_ADDER_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define CSA_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication after a fixed number of cycles.
`define CSA_ASSERT_DELAY(name, clk, rst_n, ante, n, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/csa_pkg.sv =====
package csa_pkg;

	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int SECS_W  = 32;
	localparam int WDAY_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 12'd2000;
	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd2024;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2099;

	// leap days counted up to and including 1999
	localparam int LEAPS_1999 = 484;

	// result years 2000 .. 2136
	localparam int YEAR_SPAN = 137;
	localparam logic [7:0] YEAR_EST_MAX = 8'(YEAR_SPAN - 2);

	// cycles from accepted start to result strobe
	localparam int LATENCY = 10;

	// reciprocal constants for division by constants
	localparam logic [12:0] DIV100_MUL = 13'd5243;      // x/100, shift 19
	localparam logic [25:0] DAY_MUL    = 26'd50903317;  // (x>>7)/675, shift 35
	localparam logic [11:0] YEAR_MUL   = 12'd2871;      // year estimate, shift 20
	localparam logic [16:0] DIV7_MUL   = 17'd74899;     // x/7, shift 19
	localparam logic [13:0] HOUR_MUL   = 14'd9321;      // (x>>4)/225, shift 21
	localparam logic [10:0] MIN_MUL    = 11'd1093;      // (x>>2)/15, shift 14

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_YEAR = 2'd0,
		CFG_MAX_YEAR = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic        vld;
		logic        ok;
		logic [31:0] base;
		logic [31:0] offset;
	} fwd_beat_t;

	typedef logic [15:0] ystart_t [0:YEAR_SPAN];
	typedef logic yleap_t [0:YEAR_SPAN-1];

	function automatic logic greg_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic ystart_t year_start_table();
		ystart_t t;
		int unsigned acc;
		acc = 0;
		for (int k = 0; k <= YEAR_SPAN; k++) begin
			t[k] = 16'(acc);
			acc = acc + (greg_leap(2000 + k) ? 366 : 365);
		end
		return t;
	endfunction

	function automatic yleap_t year_leap_table();
		yleap_t t;
		for (int k = 0; k < YEAR_SPAN; k++) begin
			t[k] = greg_leap(2000 + k);
		end
		return t;
	endfunction

	// first day of each result year, counted from 2000-01-01
	localparam ystart_t YEAR_START = year_start_table();
	localparam yleap_t  YEAR_LEAP  = year_leap_table();

	// days of a common year before the given month; out-of-range months saturate
	function automatic logic [8:0] month_cum(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd365;
		endcase
		return r;
	endfunction

	// length of a month, zero for codes that are no month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/calendar_seconds_adder.sv =====
// Calendar seconds adder.
// Input: pulse start with a date, a time of day and a 32-bit offset in
// seconds on the in_* and offset_seconds ports; the beat is taken at a clock
// edge where start is high and busy is low. busy stays low: a new beat may
// enter in every cycle.
// Output: done is high for one cycle with the beat's result: the validity
// flag, the input as seconds since 2000-01-01, and the date, time and
// weekday (Monday 1 .. Sunday 7) of input plus offset, modulo 2^32 seconds.
// The path from start to done runs through ten pipeline stages:
// three for date to seconds, seven for the offset add and seconds to date.
// Throughput is one beat per cycle; results leave in input order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 lowest
// valid year, 1 highest valid year); other indexes are ignored. Write only
// while no beat is in flight.
// Reset clears the pipeline valid bits and loads the year window 2024..2099.
// The receiver has no stall: every result is shown for its one cycle only.
`include "calendar_seconds_adder_assert.svh"

module calendar_seconds_adder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [csa_pkg::YEAR_W-1:0]       in_year,
	input  logic [csa_pkg::MONTH_W-1:0]      in_month,
	input  logic [csa_pkg::DAY_W-1:0]        in_day,
	input  logic [csa_pkg::HOUR_W-1:0]       in_hour,
	input  logic [csa_pkg::MIN_W-1:0]        in_minute,
	input  logic [csa_pkg::SEC_W-1:0]        in_second,
	input  logic [csa_pkg::SECS_W-1:0]       offset_seconds,
	input  logic                             cfg_we,
	input  logic [csa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csa_pkg::YEAR_W-1:0]       cfg_wdata,
	output logic                             done,
	output logic                             input_valid,
	output logic [csa_pkg::SECS_W-1:0]       base_seconds,
	output logic [csa_pkg::YEAR_W-1:0]       out_year,
	output logic [csa_pkg::MONTH_W-1:0]      out_month,
	output logic [csa_pkg::DAY_W-1:0]        out_day,
	output logic [csa_pkg::HOUR_W-1:0]       out_hour,
	output logic [csa_pkg::MIN_W-1:0]        out_minute,
	output logic [csa_pkg::SEC_W-1:0]        out_second,
	output logic [csa_pkg::WDAY_W-1:0]       out_weekday
);

	logic [csa_pkg::YEAR_W-1:0] min_year_q, max_year_q;
	csa_pkg::fwd_beat_t         fwd_beat;

	assign busy = 1'b0;

	// hold the year window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= csa_pkg::MIN_YEAR_RST;
			max_year_q <= csa_pkg::MAX_YEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				csa_pkg::CFG_MIN_YEAR: min_year_q <= cfg_wdata;
				csa_pkg::CFG_MAX_YEAR: max_year_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	csa_fwd u_fwd (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_vld         (start && !busy),
		.in_year        (in_year),
		.in_month       (in_month),
		.in_day         (in_day),
		.in_hour        (in_hour),
		.in_minute      (in_minute),
		.in_second      (in_second),
		.offset_seconds (offset_seconds),
		.min_year       (min_year_q),
		.max_year       (max_year_q),
		.beat           (fwd_beat)
	);

	csa_rev u_rev (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (fwd_beat),
		.done         (done),
		.input_valid  (input_valid),
		.base_seconds (base_seconds),
		.out_year     (out_year),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_hour     (out_hour),
		.out_minute   (out_minute),
		.out_second   (out_second),
		.out_weekday  (out_weekday)
	);

	`CSA_ASSERT_DELAY(a_start_gives_done, clk, arst_n, start && !busy, csa_pkg::LATENCY, done, "accepted beat gave no result")
	`CSA_ASSERT_IMPLY(a_done_has_start, clk, arst_n, done, $past(start && !busy, csa_pkg::LATENCY), "result without accepted beat")
	`CSA_ASSERT_IMPLY(a_result_date_legal, clk, arst_n, done, (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1) && (out_weekday >= 3'd1) && (out_weekday <= 3'd7), "result date out of range")

endmodule

// ===== rtl/core/csa_fwd.sv =====
module csa_fwd (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic [csa_pkg::YEAR_W-1:0]       in_year,
	input  logic [csa_pkg::MONTH_W-1:0]      in_month,
	input  logic [csa_pkg::DAY_W-1:0]        in_day,
	input  logic [csa_pkg::HOUR_W-1:0]       in_hour,
	input  logic [csa_pkg::MIN_W-1:0]        in_minute,
	input  logic [csa_pkg::SEC_W-1:0]        in_second,
	input  logic [csa_pkg::SECS_W-1:0]       offset_seconds,
	input  logic [csa_pkg::YEAR_W-1:0]       min_year,
	input  logic [csa_pkg::YEAR_W-1:0]       max_year,
	output csa_pkg::fwd_beat_t               beat
);

	// stage 1: register fields, divide year by 100 and 400
	logic [11:0] yprev;
	logic [24:0] y100_p, n100_p;
	logic [22:0] y400_p, n400_p;

	logic        vld_s1, win_s1;
	logic [11:0] year_s1, yprev_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1, hour_s1;
	logic [5:0]  minute_s1, second_s1;
	logic [31:0] off_s1;
	logic [5:0]  y100_s1, n100_s1;
	logic [3:0]  y400_s1, n400_s1;

	assign yprev  = in_year - 12'd1;
	assign y100_p = 25'(in_year) * 25'(csa_pkg::DIV100_MUL);
	assign n100_p = 25'(yprev) * 25'(csa_pkg::DIV100_MUL);
	assign y400_p = 23'(in_year[11:2]) * 23'(csa_pkg::DIV100_MUL);
	assign n400_p = 23'(yprev[11:2]) * 23'(csa_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		year_s1   <= in_year;
		yprev_s1  <= yprev;
		month_s1  <= in_month;
		day_s1    <= in_day;
		hour_s1   <= in_hour;
		minute_s1 <= in_minute;
		second_s1 <= in_second;
		off_s1    <= offset_seconds;
		y100_s1   <= y100_p[24:19];
		n100_s1   <= n100_p[24:19];
		y400_s1   <= y400_p[22:19];
		n400_s1   <= n400_p[22:19];
		win_s1    <= (in_year >= min_year) && (in_year <= max_year);
	end

	// stage 2: leap rule, whole years and months in days, time of day
	logic        leap_c, ok_c;
	logic [20:0] dy_c, dtot_c;
	logic [9:0]  cm_c;
	logic [4:0]  mdays_c;
	logic [16:0] tsec_c;

	logic        vld_s2, ok_s2;
	logic [20:0] dtot_s2;
	logic [16:0] tsec_s2;
	logic [31:0] off_s2;

	always_comb begin
		leap_c = ((year_s1[1:0] == 2'b00) && (year_s1 != 12'({6'd0, y100_s1} * 12'd100)))
			|| (year_s1 == 12'({8'd0, y400_s1} * 12'd400));
		if (year_s1 > csa_pkg::EPOCH_YEAR) begin
			dy_c = 21'(year_s1 - csa_pkg::EPOCH_YEAR) * 21'd365 + 21'(yprev_s1[11:2])
				- 21'(n100_s1) + 21'(n400_s1) - 21'(csa_pkg::LEAPS_1999);
		end else begin
			dy_c = '0;
		end
		cm_c    = 10'(csa_pkg::month_cum(month_s1)) + 10'(leap_c && (month_s1 >= 4'd3));
		dtot_c  = dy_c + 21'(cm_c) + 21'(day_s1);
		mdays_c = csa_pkg::month_len(month_s1, leap_c);
		ok_c    = win_s1 && (month_s1 >= 4'd1) && (month_s1 <= 4'd12)
			&& (day_s1 != 5'd0) && (day_s1 <= mdays_c)
			&& (hour_s1 <= 5'd23) && (minute_s1 <= 6'd59) && (second_s1 <= 6'd59);
		tsec_c  = 17'(hour_s1) * 17'd3600 + 17'(minute_s1) * 17'd60 + 17'(second_s1);
	end

	always_ff @(posedge clk) begin
		ok_s2   <= ok_c;
		dtot_s2 <= dtot_c;
		tsec_s2 <= tsec_c;
		off_s2  <= off_s1;
	end

	// stage 3: days to seconds, wrapping at 32 bits
	logic        vld_s3, ok_s3;
	logic [31:0] base_s3, off_s3;

	always_ff @(posedge clk) begin
		ok_s3   <= ok_s2;
		base_s3 <= 32'(dtot_s2) * 32'd86400 + 32'(tsec_s2) - 32'd86400;
		off_s3  <= off_s2;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign beat = '{vld: vld_s3, ok: ok_s3, base: base_s3, offset: off_s3};

endmodule

// ===== rtl/core/csa_rev.sv =====
module csa_rev (
	input  logic                             clk,
	input  logic                             arst_n,
	input  csa_pkg::fwd_beat_t               beat,
	output logic                             done,
	output logic                             input_valid,
	output logic [csa_pkg::SECS_W-1:0]       base_seconds,
	output logic [csa_pkg::YEAR_W-1:0]       out_year,
	output logic [csa_pkg::MONTH_W-1:0]      out_month,
	output logic [csa_pkg::DAY_W-1:0]        out_day,
	output logic [csa_pkg::HOUR_W-1:0]       out_hour,
	output logic [csa_pkg::MIN_W-1:0]        out_minute,
	output logic [csa_pkg::SEC_W-1:0]        out_second,
	output logic [csa_pkg::WDAY_W-1:0]       out_weekday
);

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	// stage 4: add the offset
	logic        ok_s4;
	logic [31:0] base_s4, sum_s4;

	always_ff @(posedge clk) begin
		ok_s4   <= beat.ok;
		base_s4 <= beat.base;
		sum_s4  <= beat.base + beat.offset;
	end

	// stage 5: day count by reciprocal of 86400
	logic        ok_s5;
	logic [31:0] base_s5, sum_s5;
	logic [50:0] prod_s5;

	always_ff @(posedge clk) begin
		ok_s5   <= ok_s4;
		base_s5 <= base_s4;
		sum_s5  <= sum_s4;
		prod_s5 <= 51'(sum_s4[31:7]) * 51'(csa_pkg::DAY_MUL);
	end

	// stage 6: second of day, year estimate, day count over 7
	logic [15:0] days_c;
	logic [31:0] dsec_c, q7_p;
	logic [27:0] est_p;
	logic [7:0]  est_c;

	logic        ok_s6;
	logic [31:0] base_s6;
	logic [15:0] days_s6;
	logic [16:0] rem_s6;
	logic [7:0]  est_s6;
	logic [12:0] q7_s6;

	always_comb begin
		days_c = prod_s5[50:35];
		dsec_c = 32'(days_c) * 32'd86400;
		est_p  = 28'(days_c) * 28'(csa_pkg::YEAR_MUL);
		est_c  = (est_p[27:20] > csa_pkg::YEAR_EST_MAX) ? csa_pkg::YEAR_EST_MAX : est_p[27:20];
		q7_p   = 32'(days_c) * 32'(csa_pkg::DIV7_MUL);
	end

	always_ff @(posedge clk) begin
		ok_s6   <= ok_s5;
		base_s6 <= base_s5;
		days_s6 <= days_c;
		rem_s6  <= 17'(sum_s5 - dsec_c);
		est_s6  <= est_c;
		q7_s6   <= q7_p[31:19];
	end

	// stage 7: pick the year around the estimate, hour, day count mod 7
	logic [7:0]  est_m1, idx_c;
	logic [15:0] ts0, ts1, tsm, start_c;
	logic [26:0] hour_p;
	logic [15:0] wr_full;

	logic        ok_s7;
	logic [31:0] base_s7;
	logic [7:0]  idx_s7;
	logic [8:0]  doy_s7;
	logic [4:0]  hour_s7;
	logic [16:0] rem_s7;
	logic [2:0]  wr_s7;

	always_comb begin
		est_m1 = (est_s6 == 8'd0) ? 8'd0 : est_s6 - 8'd1;
		ts0 = csa_pkg::YEAR_START[est_s6];
		ts1 = csa_pkg::YEAR_START[est_s6 + 8'd1];
		tsm = csa_pkg::YEAR_START[est_m1];
		if (days_s6 >= ts1) begin
			idx_c   = est_s6 + 8'd1;
			start_c = ts1;
		end else if (days_s6 >= ts0) begin
			idx_c   = est_s6;
			start_c = ts0;
		end else begin
			idx_c   = est_m1;
			start_c = tsm;
		end
		hour_p  = 27'(rem_s6[16:4]) * 27'(csa_pkg::HOUR_MUL);
		wr_full = days_s6 - 16'(q7_s6) * 16'd7;
	end

	always_ff @(posedge clk) begin
		ok_s7   <= ok_s6;
		base_s7 <= base_s6;
		idx_s7  <= idx_c;
		doy_s7  <= 9'(days_s6 - start_c);
		hour_s7 <= hour_p[25:21];
		rem_s7  <= rem_s6;
		wr_s7   <= wr_full[2:0];
	end

	// stage 8: month and day of month, seconds within hour, weekday
	logic        leap_c;
	logic [3:0]  cnt_c, mon_c;
	logic [8:0]  mstart_c;
	logic [3:0]  wsum_c;
	logic [2:0]  wday_c;

	logic        ok_s8;
	logic [31:0] base_s8;
	logic [11:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  mday_s8, hour_s8;
	logic [11:0] rmin_s8;
	logic [2:0]  wday_s8;

	always_comb begin
		leap_c = csa_pkg::YEAR_LEAP[idx_s7];
		cnt_c  = '0;
		for (int k = 2; k <= 12; k++) begin
			if (doy_s7 >= 9'(csa_pkg::month_cum(4'(k))) + 9'(leap_c && (k >= 3))) begin
				cnt_c = cnt_c + 4'd1;
			end
		end
		mon_c    = cnt_c + 4'd1;
		mstart_c = csa_pkg::month_cum(mon_c) + 9'(leap_c && (mon_c >= 4'd3));
		// day zero of the count is a Saturday
		wsum_c = 4'(wr_s7) + 4'd6;
		if (wsum_c >= 4'd7) begin
			wsum_c = wsum_c - 4'd7;
		end
		wday_c = (wsum_c == 4'd0) ? 3'd7 : wsum_c[2:0];
	end

	always_ff @(posedge clk) begin
		ok_s8    <= ok_s7;
		base_s8  <= base_s7;
		year_s8  <= csa_pkg::EPOCH_YEAR + 12'(idx_s7);
		month_s8 <= mon_c;
		mday_s8  <= 5'(doy_s7 - mstart_c + 9'd1);
		hour_s8  <= hour_s7;
		rmin_s8  <= 12'(rem_s7 - 17'(hour_s7) * 17'd3600);
		wday_s8  <= wday_c;
	end

	// stage 9: minute by reciprocal of 60
	logic [20:0] min_p;
	logic        ok_s9;
	logic [31:0] base_s9;
	logic [11:0] year_s9, rmin_s9;
	logic [3:0]  month_s9;
	logic [4:0]  mday_s9, hour_s9;
	logic [5:0]  minute_s9;
	logic [2:0]  wday_s9;

	assign min_p = 21'(rmin_s8[11:2]) * 21'(csa_pkg::MIN_MUL);

	always_ff @(posedge clk) begin
		ok_s9     <= ok_s8;
		base_s9   <= base_s8;
		year_s9   <= year_s8;
		month_s9  <= month_s8;
		mday_s9   <= mday_s8;
		hour_s9   <= hour_s8;
		rmin_s9   <= rmin_s8;
		minute_s9 <= min_p[19:14];
		wday_s9   <= wday_s8;
	end

	// stage 10: second, drive the result registers
	always_ff @(posedge clk) begin
		input_valid  <= ok_s9;
		base_seconds <= base_s9;
		out_year     <= year_s9;
		out_month    <= month_s9;
		out_day      <= mday_s9;
		out_hour     <= hour_s9;
		out_minute   <= minute_s9;
		out_second   <= 6'(rmin_s9 - 12'(minute_s9) * 12'd60);
		out_weekday  <= wday_s9;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s4  <= beat.vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	assign done = vld_s10;

endmodule
